[rtl/core/adeq_pkg.sv]
// shared types, constants and command struct for the array deque
package adeq_pkg;

   // storage and field widths
   localparam int DEPTH_DEF = 16;
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 5;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] FAIL_VALUE = {DATA_W{1'b1}};

   // request opcodes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // capture request fields
      logic exec;    // evaluate request, update indices, access slot store
      logic cfg_wr;  // write capacity register
   } cmd_type;

endpackage

[rtl/core/adeq_ctrl.sv]
// controller state machine sequencing one request at a time
module adeq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              csr_valid,
   output logic              busy,
   output logic              csr_ready,
   output logic              rsp_valid,
   output adeq_pkg::cmd_type cmd
);

   adeq_pkg::state_type state_ff;
   adeq_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adeq_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      csr_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      case (state_ff)
         adeq_pkg::STATE_IDLE: begin
            busy       = 1'b0;
            csr_ready  = 1'b1;
            cmd.cfg_wr = csr_valid;
            if (start) begin
               cmd.load = 1'b1;
               state_in = adeq_pkg::STATE_EXEC;
            end
         end
         adeq_pkg::STATE_EXEC: begin
            cmd.exec = 1'b1;
            state_in = adeq_pkg::STATE_RESP;
         end
         adeq_pkg::STATE_RESP: begin
            rsp_valid = 1'b1;
            state_in  = adeq_pkg::STATE_IDLE;
         end
         default: begin
            state_in = adeq_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/adeq_dp.sv]
// datapath: indices, capacity register, slot store and response registers
module adeq_dp #(
   parameter int DEPTH = adeq_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  adeq_pkg::cmd_type             cmd,
   input  logic [adeq_pkg::OP_W-1:0]     req_opcode,
   input  logic signed [adeq_pkg::DATA_W-1:0] req_push_value,
   input  logic [adeq_pkg::CAP_W-1:0]    csr_wdata,
   output logic signed [adeq_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [adeq_pkg::STATUS_W-1:0] rsp_status
);

   // index range is -1 .. DEPTH-1
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W = $clog2(DEPTH) + 1;
   localparam int LW    = (IDX_W > 6) ? IDX_W + 1 : 7;

   localparam logic signed [IDX_W-1:0] IDX_NONE = {IDX_W{1'b1}};
   localparam logic signed [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic signed [LW-1:0]    DEPTH_L  = LW'(DEPTH);
   localparam logic signed [LW-1:0]    ONE_L    = LW'(1);

   logic [adeq_pkg::DATA_W-1:0]      mem [DEPTH];

   adeq_pkg::op_type                 op_ff;
   logic [adeq_pkg::DATA_W-1:0]      val_ff;
   logic [adeq_pkg::CAP_W-1:0]       cap_ff;
   logic signed [IDX_W-1:0]          front_ff, front_in;
   logic signed [IDX_W-1:0]          rear_ff, rear_in;
   adeq_pkg::status_type             status_ff, status_in;
   logic                             pop_ok_ff, pop_ok_in;
   logic [adeq_pkg::DATA_W-1:0]      rd_ff;

   logic                             mem_we;
   logic                             mem_re;
   logic signed [IDX_W-1:0]          mem_idx;
   logic [AW-1:0]                    mem_addr;
   logic signed [LW-1:0]             cap_l;
   logic signed [LW-1:0]             eff_cap;
   logic signed [LW-1:0]             rear_l;
   logic                             rear_full;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= adeq_pkg::op_type'(req_opcode);
         val_ff <= req_push_value;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= adeq_pkg::CAP_RESET;
      end else if (cmd.cfg_wr) begin
         cap_ff <= csr_wdata;
      end
   end

   // effective capacity clamped to 1 .. DEPTH, rear full test
   always_comb begin
      cap_l = LW'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = ONE_L;
      end else if (cap_l > DEPTH_L) begin
         eff_cap = DEPTH_L;
      end else begin
         eff_cap = cap_l;
      end
      rear_l    = LW'(rear_ff);
      rear_full = (rear_l >= (eff_cap - ONE_L));
   end

   // operation decode
   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_idx   = front_ff;
      if (cmd.exec) begin
         status_in = adeq_pkg::STATUS_DONE;
         pop_ok_in = 1'b0;
         case (op_ff)
            adeq_pkg::OP_PUSH_FRONT: begin
               if (front_ff == IDX_NONE) begin
                  status_in = adeq_pkg::STATUS_REFUSED;
               end else begin
                  mem_we   = 1'b1;
                  mem_idx  = front_ff;
                  front_in = front_ff - IDX_ONE;
               end
            end
            adeq_pkg::OP_PUSH_REAR: begin
               if (rear_full) begin
                  status_in = adeq_pkg::STATUS_REFUSED;
               end else begin
                  mem_we  = 1'b1;
                  mem_idx = rear_ff + IDX_ONE;
                  rear_in = rear_ff + IDX_ONE;
               end
            end
            adeq_pkg::OP_POP_FRONT: begin
               if (front_ff == rear_ff) begin
                  status_in = adeq_pkg::STATUS_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  pop_ok_in = 1'b1;
                  mem_idx   = front_ff + IDX_ONE;
                  front_in  = front_ff + IDX_ONE;
               end
            end
            adeq_pkg::OP_POP_REAR: begin
               if (front_ff == rear_ff) begin
                  status_in = adeq_pkg::STATUS_EMPTY;
               end else begin
                  mem_re    = 1'b1;
                  pop_ok_in = 1'b1;
                  mem_idx   = rear_ff;
                  rear_in   = rear_ff - IDX_ONE;
               end
            end
            default: begin
               status_in = adeq_pkg::STATUS_EMPTY;
            end
         endcase
      end
   end

   assign mem_addr = mem_idx[AW-1:0];

   // index and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= IDX_NONE;
         rear_ff   <= IDX_NONE;
         status_ff <= adeq_pkg::STATUS_DONE;
         pop_ok_ff <= 1'b0;
      end else begin
         front_ff  <= front_in;
         rear_ff   <= rear_in;
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   // slot store write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= val_ff;
      end
   end

   // slot store registered read
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // response fields
   assign rsp_pop_value = pop_ok_ff ? rd_ff : adeq_pkg::FAIL_VALUE;
   assign rsp_status    = status_ff;

endmodule

[rtl/core/array_double_ended_queue_top.sv]
// top level of the array deque: controller plus datapath
// Sequence: a request taken in idle is evaluated in the exec state, which updates the indices
//   and accesses the slot store; the response strobe is then raised in the resp state.
// Flow: no new request is taken until the response is out; the exec state and the registered
//   slot store read hold each request, and busy stays high until the response is out.
// Reset: synchronous, active high; indices go to minus one, capacity to 16, slot store
//   contents are undefined until written. The response is not held off by the receiver.
module array_double_ended_queue_top #(
   parameter int DEPTH = adeq_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [adeq_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [adeq_pkg::DATA_W-1:0] req_push_value,
   output logic                               rsp_valid,
   output logic signed [adeq_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [adeq_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [adeq_pkg::CAP_W-1:0]         csr_wdata
);

   adeq_pkg::cmd_type cmd;

   // sequencing
   adeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // storage and indices
   adeq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .csr_wdata      (csr_wdata),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   // every accepted transfer is answered with a response strobe
   assert property (@(posedge clock)
      (start && !busy && !reset) ##1 !reset |-> ##1 rsp_valid)
      else $error("response missing after accepted request");

   // block frees up right after a response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after response");

   // a failed operation always returns the fail value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != adeq_pkg::STATUS_DONE) |->
         (rsp_pop_value == adeq_pkg::FAIL_VALUE))
      else $error("failed operation returned data");

endmodule

[tb/array_double_ended_queue_top_tb.sv]
// self-checking testbench for the array deque: directed table, then random bursts
module array_double_ended_queue_top_tb;

   localparam int SLOTS = adeq_pkg::DEPTH_DEF;

   // one expected response
   typedef struct packed {
      logic [adeq_pkg::DATA_W-1:0] value;
      adeq_pkg::status_type        status;
   } outcome_type;

   // one row of the directed table: a request or a capacity write
   typedef enum bit {ROW_REQ, ROW_CFG} row_kind_type;
   typedef struct packed {
      row_kind_type                kind;
      logic [adeq_pkg::CAP_W-1:0]  cap;
      adeq_pkg::op_type            op;
      logic [adeq_pkg::DATA_W-1:0] value;
      bit                          fixed_exp;
      logic [adeq_pkg::DATA_W-1:0] exp_value;
      adeq_pkg::status_type        exp_status;
   } step_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [adeq_pkg::OP_W-1:0]           req_opcode = adeq_pkg::OP_PUSH_FRONT;
   logic signed [adeq_pkg::DATA_W-1:0]  req_push_value = '0;
   logic                                rsp_valid;
   logic signed [adeq_pkg::DATA_W-1:0]  rsp_pop_value;
   logic [adeq_pkg::STATUS_W-1:0]       rsp_status;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [adeq_pkg::CAP_W-1:0]          csr_wdata = adeq_pkg::CAP_RESET;

   // predictor state: slot contents, both indices and the capacity setting
   logic [adeq_pkg::DATA_W-1:0] deque_slots [SLOTS];
   int                          front_idx = -1;
   int                          rear_idx = -1;
   logic [adeq_pkg::CAP_W-1:0]  cap_setting = adeq_pkg::CAP_RESET;

   outcome_type outcome_q [$];
   int          mismatch_count = 0;
   int          n_requests = 0;
   int          cfg_writes = 0;
   int          n_done = 0;
   int          n_refused = 0;
   int          n_empty = 0;

   logic [adeq_pkg::DATA_W-1:0] corner_vals [4] =
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

   // directed table: empty pops, refused pushes, sign extremes, capacity below fill,
   // capacity zero and above depth
   step_type plan [0:22] = '{
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_FRONT,  32'h0,         1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_EMPTY},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_REAR,   32'h0,         1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_EMPTY},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_FRONT, 32'h5,         1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_REFUSED},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'h8000_0000, 1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_FRONT,  32'h0,         1'b1, 32'h7FFF_FFFF,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_FRONT, 32'h5555_5555, 1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_FRONT, 32'h1,         1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_REFUSED},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_REAR,   32'h0,         1'b1, 32'h0,
        adeq_pkg::STATUS_DONE},
      '{ROW_CFG, 5'd2,  adeq_pkg::OP_PUSH_FRONT, 32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'hAAAA_AAAA, 1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_REFUSED},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_FRONT,  32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_CFG, 5'd0,  adeq_pkg::OP_PUSH_FRONT, 32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'h3,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_REAR,   32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_REAR,   32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_REAR,   32'h0,         1'b1, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_EMPTY},
      '{ROW_CFG, 5'd31, adeq_pkg::OP_PUSH_FRONT, 32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_REQ, 5'd0,  adeq_pkg::OP_POP_FRONT,  32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE},
      '{ROW_CFG, 5'd16, adeq_pkg::OP_PUSH_FRONT, 32'h0,         1'b0, adeq_pkg::FAIL_VALUE,
        adeq_pkg::STATUS_DONE}
   };

   array_double_ended_queue_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   // one printed line per mismatch, quiet after the first fifty
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // apply one request to the shadow deque and return the response it should give
   function automatic outcome_type deque_apply(input adeq_pkg::op_type op,
                                               input logic [adeq_pkg::DATA_W-1:0] val);
      outcome_type res;
      int room;
      res.value = adeq_pkg::FAIL_VALUE;
      res.status = adeq_pkg::STATUS_DONE;
      // capacity zero acts as one, above depth acts as depth
      room = (cap_setting == '0) ? 1 :
             ((int'(cap_setting) > SLOTS) ? SLOTS : int'(cap_setting));
      case (op)
         adeq_pkg::OP_PUSH_FRONT: begin
            if (front_idx == -1) begin
               res.status = adeq_pkg::STATUS_REFUSED;
            end else begin
               deque_slots[front_idx] = val;
               front_idx--;
            end
         end
         adeq_pkg::OP_PUSH_REAR: begin
            // also refused when capacity was lowered below the fill
            if (rear_idx >= room - 1) begin
               res.status = adeq_pkg::STATUS_REFUSED;
            end else begin
               rear_idx++;
               deque_slots[rear_idx] = val;
            end
         end
         adeq_pkg::OP_POP_FRONT: begin
            if (front_idx == rear_idx) begin
               res.status = adeq_pkg::STATUS_EMPTY;
            end else begin
               front_idx++;
               res.value = deque_slots[front_idx];
            end
         end
         default: begin
            if (front_idx == rear_idx) begin
               res.status = adeq_pkg::STATUS_EMPTY;
            end else begin
               res.value = deque_slots[rear_idx];
               rear_idx--;
            end
         end
      endcase
      return res;
   endfunction

   // present one request and hold it until the transfer; start stays high for the caller
   task automatic issue(input adeq_pkg::op_type op, input logic [adeq_pkg::DATA_W-1:0] val,
                        input bit fixed_exp, input outcome_type fixed_out);
      outcome_type predicted;
      req_opcode <= op;
      req_push_value <= val;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = deque_apply(op, val);
      outcome_q.push_back(fixed_exp ? fixed_out : predicted);
      n_requests++;
   endtask

   // capacity write, only once the block has drained
   task automatic write_capacity(input logic [adeq_pkg::CAP_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (outcome_q.size() != 0 || busy);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cap_setting = value;
      cfg_writes++;
   endtask

   // response checker
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("response %h/%0d with nothing pending",
                                      rsp_pop_value, rsp_status));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_pop_value !== want.value)
               report_mismatch($sformatf("pop_value %h, expected %h",
                                         rsp_pop_value, want.value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            case (want.status)
               adeq_pkg::STATUS_DONE:    n_done++;
               adeq_pkg::STATUS_REFUSED: n_refused++;
               default:                  n_empty++;
            endcase
         end
      end
   end

   // stimulus
   initial begin : stimulus
      outcome_type                 row_out;
      adeq_pkg::op_type            bias;
      adeq_pkg::op_type            op;
      logic [adeq_pkg::DATA_W-1:0] val;
      logic [adeq_pkg::CAP_W-1:0]  cap;
      int                          run_left;
      int                          burst;
      int                          gap;

      run_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, back to back
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            write_capacity(plan[i].cap);
         end else begin
            row_out.value = plan[i].exp_value;
            row_out.status = plan[i].exp_status;
            issue(plan[i].op, plan[i].value, plan[i].fixed_exp, row_out);
         end
      end

      // random phases, each under its own capacity, ops biased in runs to reach full and empty
      row_out = '0;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       cap = 5'd16;
            1:       cap = 5'd1;
            2:       cap = 5'd31;
            3:       cap = 5'd0;
            default: cap = adeq_pkg::CAP_W'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         burst = $urandom_range(1, 20);
         for (int n = 0; n < 85; n++) begin
            if (run_left == 0) begin
               bias = adeq_pkg::op_type'($urandom_range(0, 3));
               run_left = $urandom_range(8, 30);
            end
            run_left--;
            op = ($urandom_range(0, 2) != 0) ? bias : adeq_pkg::op_type'($urandom_range(0, 3));
            val = ($urandom_range(0, 7) == 0) ? corner_vals[$urandom_range(0, 3)] : $urandom;
            issue(op, val, 1'b0, row_out);
            // sender bursts with random gaps, some gaps of zero
            burst--;
            if (burst == 0) begin
               gap = $urandom_range(0, 7);
               if (gap != 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst = $urandom_range(1, 20);
            end
         end
      end

      // drain, then a few cycles to catch stray responses
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("ran %0d requests under %0d capacity writes", n_requests, cfg_writes);
      $display("responses: %0d done, %0d refused, %0d empty", n_done, n_refused, n_empty);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/adeq_pkg.sv
rtl/core/adeq_ctrl.sv
rtl/core/adeq_dp.sv
rtl/core/array_double_ended_queue_top.sv
tb/array_double_ended_queue_top_tb.sv
